/* rtl/ptt_pkg.sv */
package ptt_pkg;

    // Field width of every time value and take position
    localparam int TIME_BITS = 48;

    // Default depth of the interval table
    localparam int MAX_SEGMENTS_DEF = 16;

    // Most spans one split request may give
    localparam int MAX_RESULTS = 16;
    localparam int CNT_BITS = $clog2(MAX_RESULTS + 1);

    typedef logic [TIME_BITS-1:0] t_time;

    // Request codes
    typedef enum logic [2:0] {
        CMD_START  = 3'd0,
        CMD_PAUSE  = 3'd1,
        CMD_RESUME = 3'd2,
        CMD_LOCATE = 3'd3,
        CMD_SPLIT  = 3'd4
    } t_cmd;

    typedef struct packed {
        logic [2:0] command;
        t_time      time_a;
        t_time      time_b;
    } t_in_req;

    typedef struct packed {
        logic  found;
        t_time position;
        t_time span_begin;
        t_time span_end;
        t_time elapsed;
        logic  table_full;
        logic  last;
    } t_out_req;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_ELAP,
        S_L_CHK,
        S_L_POS,
        S_S1_CHK,
        S_S1_EVAL,
        S_S1_END,
        S_S2_CHK,
        S_S2_EVAL,
        S_S2_POS,
        S_S2_EMIT,
        S_OUT
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;    // take the request, clear located result
        logic update;     // apply start, pause or resume to the timeline
        logic elapse;     // work out the recorded duration
        logic walk_init;  // point at the newest interval, clear span tally
        logic idx_dec;    // step to the older interval
        logic idx_inc;    // step to the newer interval
        logic idx_low;    // jump to the oldest interval of the split
        logic span_calc;  // clip the interval to the window
        logic span_tally; // count a span on the downward pass
        logic sub_calc;   // offset of the point inside the interval
        logic pos_calc;   // take position of the point
        logic emit;       // load the result register
        logic emit_span;  // the result is a split span
    } t_ctrl;

    // Status from datapath to controller
    typedef struct packed {
        logic is_locate;
        logic is_split;
        logic count_zero;
        logic loc_before;
        logic loc_hit;
        logic stop;
        logic nonempty;
        logic idx_zero;
        logic idx_high;
        logic cnt_last;
        logic cnt_zero;
        logic out_free;
    } t_stat;

endpackage

/* rtl/ptt_ctrl.sv */
module ptt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  ptt_pkg::t_stat i_stat,
    output logic           o_in_stall,
    output ptt_pkg::t_ctrl o_ctrl
);
    import ptt_pkg::*;

    t_state r_state;
    t_state n_state;

    // Hold the state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Advance the sequence
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: n_state = S_ELAP;
            S_ELAP: begin
                if (i_stat.is_locate && !i_stat.count_zero) begin
                    n_state = S_L_CHK;
                end else if (i_stat.is_split && !i_stat.count_zero) begin
                    n_state = S_S1_CHK;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_L_CHK: begin
                if (i_stat.loc_before) begin
                    if (i_stat.idx_zero) begin
                        n_state = S_OUT;
                    end
                end else if (i_stat.loc_hit) begin
                    n_state = S_L_POS;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_L_POS: n_state = S_OUT;
            S_S1_CHK: n_state = S_S1_EVAL;
            S_S1_EVAL: begin
                if (i_stat.stop || (i_stat.nonempty && i_stat.cnt_last) || i_stat.idx_zero) begin
                    n_state = S_S1_END;
                end else begin
                    n_state = S_S1_CHK;
                end
            end
            S_S1_END: begin
                if (i_stat.cnt_zero) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_S2_CHK;
                end
            end
            S_S2_CHK: n_state = S_S2_EVAL;
            S_S2_EVAL: begin
                if (i_stat.nonempty) begin
                    n_state = S_S2_POS;
                end else begin
                    n_state = S_S2_CHK;
                end
            end
            S_S2_POS: n_state = S_S2_EMIT;
            S_S2_EMIT: begin
                if (i_stat.out_free) begin
                    if (i_stat.idx_high) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_S2_CHK;
                    end
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Drive datapath commands
    always_comb begin
        o_ctrl     = '0;
        o_in_stall = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: o_ctrl.capture = i_in_valid;
            S_EXEC: o_ctrl.update = 1'b1;
            S_ELAP: begin
                o_ctrl.elapse    = 1'b1;
                o_ctrl.walk_init = (i_stat.is_locate || i_stat.is_split) && !i_stat.count_zero;
            end
            S_L_CHK: begin
                o_ctrl.idx_dec  = i_stat.loc_before && !i_stat.idx_zero;
                o_ctrl.sub_calc = !i_stat.loc_before && i_stat.loc_hit;
            end
            S_L_POS: o_ctrl.pos_calc = 1'b1;
            S_S1_CHK: o_ctrl.span_calc = 1'b1;
            S_S1_EVAL: begin
                o_ctrl.span_tally = !i_stat.stop;
                o_ctrl.idx_dec    = !i_stat.stop && !(i_stat.nonempty && i_stat.cnt_last)
                                    && !i_stat.idx_zero;
            end
            S_S1_END: o_ctrl.idx_low = !i_stat.cnt_zero;
            S_S2_CHK: o_ctrl.span_calc = 1'b1;
            S_S2_EVAL: begin
                o_ctrl.sub_calc = i_stat.nonempty;
                o_ctrl.idx_inc  = !i_stat.nonempty;
            end
            S_S2_POS: o_ctrl.pos_calc = 1'b1;
            S_S2_EMIT: begin
                o_ctrl.emit      = i_stat.out_free;
                o_ctrl.emit_span = 1'b1;
                o_ctrl.idx_inc   = i_stat.out_free && !i_stat.idx_high;
            end
            S_OUT: o_ctrl.emit = i_stat.out_free;
            default: o_ctrl = '0;
        endcase
    end

endmodule

/* rtl/ptt_dp.sv */
module ptt_dp #(
    parameter int MAX_SEGMENTS = ptt_pkg::MAX_SEGMENTS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ptt_pkg::t_in_req i_in,
    input  ptt_pkg::t_ctrl   i_ctrl,
    input  logic             i_out_stall,
    output ptt_pkg::t_stat   o_stat,
    output logic             o_out_valid,
    output ptt_pkg::t_out_req o_out
);
    import ptt_pkg::*;

    localparam int IDX_BITS = $clog2(MAX_SEGMENTS);
    localparam int SEG_BITS = $clog2(MAX_SEGMENTS + 1);
    localparam logic [SEG_BITS-1:0] SEG_MAX = SEG_BITS'(MAX_SEGMENTS);
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(MAX_RESULTS - 1);

    // Saturating add of two time values
    function automatic t_time sat_add(input t_time x, input t_time y);
        logic [TIME_BITS:0] s;
        s = {1'b0, x} + {1'b0, y};
        return s[TIME_BITS] ? '1 : s[TIME_BITS-1:0];
    endfunction

    // Interval table
    t_time mem_begin  [MAX_SEGMENTS];
    t_time mem_end    [MAX_SEGMENTS];
    t_time mem_offset [MAX_SEGMENTS];

    // Timeline state
    logic [SEG_BITS-1:0] r_count, n_count;
    t_time               r_run_start, n_run_start;
    t_time               r_total, n_total;
    logic                r_paused, n_paused;
    logic                r_full, n_full;

    // Request and working registers
    logic [2:0]          r_cmd;
    t_time               r_a, r_b;
    logic                r_gt;
    t_time               r_diff;
    t_time               r_elapsed;
    logic                r_found;
    t_time               r_pos;
    logic [IDX_BITS-1:0] r_idx, n_idx;
    logic [IDX_BITS-1:0] r_low, r_high;
    logic [CNT_BITS-1:0] r_cnt;
    t_time               r_first, r_lastt, r_sub;
    logic                r_stop;
    t_time               r_q_begin, r_q_end, r_q_offset;
    logic                r_out_valid;
    t_out_req            r_out;

    // Table write port
    logic                w_bo_en, w_end_en, w_clear_gt;
    logic [IDX_BITS-1:0] w_addr;
    t_time               w_begin, w_offset, w_end;

    logic [SEG_BITS-1:0] count_m1;
    logic [IDX_BITS-1:0] last_idx;
    logic                seg_open, nonempty, out_free;
    t_time               span_first, span_lastt, sub_op;

    assign count_m1   = r_count - SEG_BITS'(1);
    assign last_idx   = count_m1[IDX_BITS-1:0];
    assign seg_open   = (r_idx == last_idx) && !r_paused;
    assign span_first = (r_a > r_q_begin) ? r_a : r_q_begin;
    assign span_lastt = (seg_open || (r_b < r_q_end)) ? r_b : r_q_end;
    assign nonempty   = r_first < r_lastt;
    assign sub_op     = (r_cmd == CMD_LOCATE) ? r_a : r_first;
    assign out_free   = !r_out_valid || !i_out_stall;

    // Apply start, pause and resume
    always_comb begin
        n_count     = r_count;
        n_run_start = r_run_start;
        n_total     = r_total;
        n_paused    = r_paused;
        n_full      = r_full;
        w_bo_en     = 1'b0;
        w_end_en    = 1'b0;
        w_clear_gt  = 1'b0;
        w_addr      = last_idx;
        w_begin     = r_a;
        w_offset    = r_total;
        w_end       = r_gt ? r_a : r_run_start;
        if (i_ctrl.update) begin
            case (r_cmd)
                CMD_START: begin
                    n_count     = SEG_BITS'(1);
                    n_run_start = r_a;
                    n_total     = '0;
                    n_paused    = 1'b0;
                    n_full      = 1'b0;
                    w_bo_en     = 1'b1;
                    w_addr      = '0;
                    w_offset    = '0;
                    w_clear_gt  = 1'b1;
                end
                CMD_PAUSE: begin
                    if (r_count != '0 && !r_paused) begin
                        w_end_en = 1'b1;
                        n_total  = sat_add(r_total, r_gt ? r_diff : '0);
                        n_paused = 1'b1;
                    end
                end
                CMD_RESUME: begin
                    if (r_count != '0 && r_paused) begin
                        if (r_count >= SEG_MAX) begin
                            n_full = 1'b1;
                        end else begin
                            w_bo_en     = 1'b1;
                            w_addr      = r_count[IDX_BITS-1:0];
                            n_count     = r_count + SEG_BITS'(1);
                            n_run_start = r_a;
                            n_paused    = 1'b0;
                            w_clear_gt  = 1'b1;
                        end
                    end
                end
                default: begin
                    n_count = r_count;
                end
            endcase
        end
    end

    // Step the table index
    always_comb begin
        n_idx = r_idx;
        if (i_ctrl.walk_init) begin
            n_idx = last_idx;
        end else if (i_ctrl.idx_low) begin
            n_idx = r_low;
        end else if (i_ctrl.idx_dec) begin
            n_idx = r_idx - IDX_BITS'(1);
        end else if (i_ctrl.idx_inc) begin
            n_idx = r_idx + IDX_BITS'(1);
        end
    end

    // Write the table and read the entry the index will point at
    always_ff @(posedge i_clk) begin
        if (w_bo_en) begin
            mem_begin[w_addr]  <= w_begin;
            mem_offset[w_addr] <= w_offset;
        end
        if (w_end_en) begin
            mem_end[w_addr] <= w_end;
        end
        r_q_begin  <= mem_begin[n_idx];
        r_q_end    <= mem_end[n_idx];
        r_q_offset <= mem_offset[n_idx];
    end

    // Hold timeline state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_run_start <= '0;
            r_total     <= '0;
            r_paused    <= 1'b0;
            r_full      <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_run_start <= n_run_start;
            r_total     <= n_total;
            r_paused    <= n_paused;
            r_full      <= n_full;
        end
    end

    // Working registers of one request
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (i_ctrl.capture) begin
            r_cmd   <= i_in.command;
            r_a     <= i_in.time_a;
            r_b     <= i_in.time_b;
            r_gt    <= i_in.time_a > r_run_start;
            r_diff  <= i_in.time_a - r_run_start;
            r_found <= 1'b0;
            r_pos   <= '0;
        end else if (w_clear_gt) begin
            r_gt <= 1'b0;
        end
        if (i_ctrl.elapse) begin
            if (r_count == '0) begin
                r_elapsed <= '0;
            end else if (r_paused || !r_gt) begin
                r_elapsed <= r_total;
            end else begin
                r_elapsed <= sat_add(r_total, r_diff);
            end
        end
        if (i_ctrl.walk_init) begin
            r_cnt <= '0;
        end else if (i_ctrl.span_tally && nonempty) begin
            r_cnt <= r_cnt + CNT_BITS'(1);
            r_low <= r_idx;
            if (r_cnt == '0) begin
                r_high <= r_idx;
            end
        end
        if (i_ctrl.span_calc) begin
            r_first <= span_first;
            r_lastt <= span_lastt;
            r_stop  <= !seg_open && (r_q_end <= r_a);
        end
        if (i_ctrl.sub_calc) begin
            r_sub <= sub_op - r_q_begin;
        end
        if (i_ctrl.pos_calc) begin
            r_pos   <= sat_add(r_q_offset, r_sub);
            r_found <= 1'b1;
        end
    end

    // Result register: load on emit, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.emit) begin
            r_out.position   <= r_pos;
            r_out.elapsed    <= r_elapsed;
            r_out.table_full <= r_full;
            if (i_ctrl.emit_span) begin
                r_out.found      <= 1'b1;
                r_out.span_begin <= r_first;
                r_out.span_end   <= r_lastt;
                r_out.last       <= (r_idx == r_high);
            end else begin
                r_out.found      <= r_found;
                r_out.span_begin <= '0;
                r_out.span_end   <= '0;
                r_out.last       <= 1'b1;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Status back to the controller
    always_comb begin
        o_stat.is_locate  = (r_cmd == CMD_LOCATE);
        o_stat.is_split   = (r_cmd == CMD_SPLIT);
        o_stat.count_zero = (r_count == '0);
        o_stat.loc_before = (r_a < r_q_begin);
        o_stat.loc_hit    = seg_open || (r_a < r_q_end);
        o_stat.stop       = r_stop;
        o_stat.nonempty   = nonempty;
        o_stat.idx_zero   = (r_idx == '0);
        o_stat.idx_high   = (r_idx == r_high);
        o_stat.cnt_last   = (r_cnt == CNT_LAST);
        o_stat.cnt_zero   = (r_cnt == '0);
        o_stat.out_free   = out_free;
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= SEG_MAX)
        else $error("interval count beyond table depth");

    a_paused_started: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_paused |-> (r_count != '0))
        else $error("paused without a started take");

    a_full_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |-> (r_paused && r_count == SEG_MAX))
        else $error("full flag set while table not full or running");

    a_emit_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.emit |-> out_free)
        else $error("result loaded over a stalled result");

endmodule

/* rtl/pausable_take_timeline.sv */
// Recording timeline with pause and resume.
// Input channel: i_in_valid / o_in_stall carry one request (command, time_a,
// time_b). Output channel: o_out_valid / i_out_stall carry result requests.
// One request is worked on at a time; o_in_stall is low only when idle.
// Start, pause, resume and unknown commands give one result, and the next
// request can be taken once that result is loaded into the output register.
// Locate checks one interval a cycle from the newest down. Split walks the
// table twice, one read port on the interval memory: down from the newest
// interval to count the spans, then up from the oldest span's interval,
// emitting one result per span. Results of one request come in order, the
// final one with last set.
// Reset clears the interval count and timeline state; the table
// itself is not cleared, since only entries below the count are read.
// When the receiver stalls, the pending result stays in the output register
// and the sequence waits at its next result; an input request is accepted
// while the previous result still waits.
module pausable_take_timeline #(
    parameter int MAX_SEGMENTS = ptt_pkg::MAX_SEGMENTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  ptt_pkg::t_in_req  i_in,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output ptt_pkg::t_out_req o_out
);
    import ptt_pkg::*;

    t_ctrl ctrl;
    t_stat stat;

    ptt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_ctrl     (ctrl)
    );

    ptt_dp #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_ctrl      (ctrl),
        .i_out_stall (i_out_stall),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule
